// ===== rtl/nrrm_pkg.sv =====
`default_nettype none
package nrrm_pkg;

  localparam int unsigned IdW      = 16;
  localparam int unsigned CodeW    = 4;
  localparam int unsigned TimeoutW = 8;
  localparam int unsigned LimitW   = 4;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CountW   = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [TimeoutW-1:0] RetryTimeoutReset = TimeoutW'(5);
  localparam logic [LimitW-1:0]   RetryLimitReset   = LimitW'(3);
  localparam logic [DelayW-1:0]   FailDelayReset    = DelayW'(5 * 60);
  localparam logic [IdW-1:0]      StartIdReset      = '0;

  typedef enum logic [1:0] {
    REG_RETRY_TIMEOUT = 2'd0,
    REG_RETRY_LIMIT   = 2'd1,
    REG_FAIL_DELAY    = 2'd2,
    REG_START_ID      = 2'd3
  } reg_index_t;

  typedef enum logic {
    KIND_TICK     = 1'b0,
    KIND_RESPONSE = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic           rejected;
    logic           registered;
    logic [IdW-1:0] send_id;
    logic           is_demand;
    logic           send_now;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/name_registration_retry_machine.sv =====
`default_nettype none
// a result is registered into the output register when its item is taken
// throughput: one item per cycle while m_tready drains the output; the state update sits in one compare/decrement stage
// s_tready stays high while the output register is empty or being drained
// reset (rst, synchronous) clears the state, loads the register defaults and
// sets the id counter to zero; no clearing pass follows reset
module name_registration_retry_machine
  import nrrm_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [InDataW-1:0]   s_tdata,   // resp_id[15:0], resp_code[19:16], zero pad
  input  wire                  s_tuser,   // kind
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [OutDataW-1:0]  m_tdata,   // send_now, send_id, registered, rejected, zero pad
  output logic                 m_tuser,   // is_demand
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [AddrW-1:0]     paddr,
  input  wire  [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  logic [TimeoutW-1:0] retry_timeout;
  logic [LimitW-1:0]   retry_limit;
  logic [DelayW-1:0]   fail_delay;
  logic [IdW-1:0]      start_id;

  logic                done_flag, done_flag_next;
  logic [LimitW-1:0]   attempt_count, attempt_count_next;
  logic [CountW-1:0]   countdown, countdown_next;
  logic [IdW-1:0]      current_id, current_id_next;

  result_t             result, result_next;
  logic                out_valid;

  logic                take;
  logic                cfg_write;
  reg_index_t          cfg_index;
  logic [IdW-1:0]      resp_id;
  logic [CodeW-1:0]    resp_code;
  logic [CountW-1:0]   count_dec;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  assign s_tready = ~out_valid | m_tready;
  assign take     = s_tvalid & s_tready;

  assign resp_id   = s_tdata[IdW-1:0];
  assign resp_code = s_tdata[IdW+CodeW-1:IdW];

  always_comb begin
    unique case (cfg_index)
      REG_RETRY_TIMEOUT: prdata = DataW'(retry_timeout);
      REG_RETRY_LIMIT:   prdata = DataW'(retry_limit);
      REG_FAIL_DELAY:    prdata = DataW'(fail_delay);
      REG_START_ID:      prdata = DataW'(start_id);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    done_flag_next     = done_flag;
    attempt_count_next = attempt_count;
    current_id_next    = current_id;
    count_dec          = (countdown != '0) ? countdown - CountW'(1) : countdown;
    countdown_next     = countdown;
    result_next        = '0;

    if (item_kind_t'(s_tuser) == KIND_TICK) begin
      countdown_next = count_dec;
      if (count_dec == '0 && !done_flag) begin
        current_id_next      = current_id + IdW'(1);
        result_next.send_now = 1'b1;
        // enough unanswered requests: claim the name with a demand
        if (attempt_count >= retry_limit) begin
          done_flag_next        = 1'b1;
          result_next.is_demand = 1'b1;
        end else begin
          attempt_count_next = attempt_count + LimitW'(1);
          countdown_next     = CountW'(retry_timeout);
        end
      end
    end else if (resp_id == current_id && resp_code != '0) begin
      attempt_count_next   = '0;
      countdown_next       = CountW'(fail_delay);
      result_next.rejected = 1'b1;
    end

    result_next.send_id    = current_id_next;
    result_next.registered = done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_timeout <= RetryTimeoutReset;
      retry_limit   <= RetryLimitReset;
      fail_delay    <= FailDelayReset;
      start_id      <= StartIdReset;
      done_flag     <= 1'b0;
      attempt_count <= '0;
      countdown     <= '0;
      current_id    <= StartIdReset;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        done_flag     <= done_flag_next;
        attempt_count <= attempt_count_next;
        countdown     <= countdown_next;
        current_id    <= current_id_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // config writes must arrive only while idle so they never race an item; the block does not enforce this
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RETRY_TIMEOUT: retry_timeout <= pwdata[TimeoutW-1:0];
          REG_RETRY_LIMIT:   retry_limit   <= pwdata[LimitW-1:0];
          REG_FAIL_DELAY:    fail_delay    <= pwdata[DelayW-1:0];
          REG_START_ID: begin
            start_id   <= pwdata[IdW-1:0];
            current_id <= pwdata[IdW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = result.is_demand;
  assign m_tdata  = {{(OutDataW - IdW - 3){1'b0}}, result.rejected, result.registered,
                     result.send_id, result.send_now};

endmodule
`default_nettype wire

// ===== bench/name_registration_retry_machine_tb.sv =====
`timescale 1ns / 1ps

module name_registration_retry_machine_tb;
  import nrrm_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    item_kind_t     kind;
    logic [IdW-1:0] rid;
    logic [CodeW-1:0] code;
    bit             track;    // response id follows the live transaction id
    logic [IdW-1:0] skew;
    int unsigned    gap;
  } claim_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;   // resp_id[15:0], resp_code[19:16], zero pad
  logic s_tuser = 1'b0;               // kind
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;       // send_now, send_id, registered, rejected, zero pad
  logic m_tuser;                      // is_demand
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  name_registration_retry_machine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow of the claim machine
  logic [TimeoutW-1:0] cfg_timeout = RetryTimeoutReset;
  logic [LimitW-1:0]   cfg_limit   = RetryLimitReset;
  logic [DelayW-1:0]   cfg_delay   = FailDelayReset;
  logic                claimed     = 1'b0;
  logic [LimitW-1:0]   attempts    = '0;
  logic [CountW-1:0]   secs_left   = '0;
  logic [IdW-1:0]      txn_id      = '0;

  claim_item_t item_backlog[$];
  result_t     awaited_results[$];
  claim_item_t staged;
  result_t     want, got;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_n;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          allow_claim = 1'b0;
  int unsigned errors = 0;
  int unsigned n_items = 0, n_bcasts = 0, n_demands = 0, n_rejects = 0;
  int unsigned cycles = 0;

  function automatic result_t advance_claim(item_kind_t kind, logic [IdW-1:0] rid,
                                            logic [CodeW-1:0] code);
    result_t r;
    r = '0;
    if (kind == KIND_TICK) begin
      if (secs_left != 0) secs_left = secs_left - 1'b1;
      if (secs_left == 0 && !claimed) begin
        txn_id = txn_id + 1'b1;
        r.send_now = 1'b1;
        if (attempts >= cfg_limit) begin
          claimed = 1'b1;
          r.is_demand = 1'b1;
        end else begin
          attempts = attempts + 1'b1;
          secs_left = CountW'(cfg_timeout);
        end
      end
    end else if (rid == txn_id && code != 0) begin
      attempts = '0;
      secs_left = cfg_delay;
      r.rejected = 1'b1;
    end
    r.send_id = txn_id;
    r.registered = claimed;
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(advance_claim(item_kind_t'(s_tuser), s_tdata[IdW-1:0],
                                                s_tdata[IdW+CodeW-1:IdW]));
        n_items++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (item_backlog.size() != 0) begin
          staged = item_backlog.pop_front();
          if (staged.track) staged.rid = txn_id + staged.skew;
          // keep the name unclaimed: object right before the demand would go out
          if (!allow_claim && staged.kind == KIND_TICK && !claimed &&
              attempts >= cfg_limit && secs_left <= 1) begin
            staged.kind = KIND_RESPONSE;
            staged.rid = txn_id;
            staged.code = CodeW'($urandom_range(1, 15));
          end
          s_tvalid <= 1'b1;
          s_tuser <= staged.kind;
          s_tdata <= {{(InDataW-IdW-CodeW){1'b0}}, staged.code, staged.rid};
          gap_left <= staged.gap;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      got.send_now = m_tdata[0];
      got.send_id = m_tdata[IdW:1];
      got.registered = m_tdata[IdW+1];
      got.rejected = m_tdata[IdW+2];
      got.is_demand = m_tuser;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h/%b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("send_now", want.send_now, got.send_now);
        check_field("is_demand", want.is_demand, got.is_demand);
        check_field("send_id", want.send_id, got.send_id);
        check_field("registered", want.registered, got.registered);
        check_field("rejected", want.rejected, got.rejected);
        n_bcasts += want.send_now;
        n_demands += want.is_demand;
        n_rejects += want.rejected;
      end
      hold_n = rx_quiet ? 0 : $urandom_range(0, 10);
      if (hold_n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        stall_left <= hold_n - 1;
      end
    end else if (!m_tready) begin
      if (stall_left == 0) m_tready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: run stalled after %0d cycles", $time, cycles);
      $display("[name_registration_retry_machine] ERROR");
      $finish;
    end
  end

  task automatic apb_write(reg_index_t idx, logic [DataW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RETRY_TIMEOUT: cfg_timeout = val[TimeoutW-1:0];
      REG_RETRY_LIMIT:   cfg_limit = val[LimitW-1:0];
      REG_FAIL_DELAY:    cfg_delay = val[DelayW-1:0];
      REG_START_ID:      txn_id = val[IdW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_knobs(int unsigned t, int unsigned l, int unsigned d, int unsigned s);
    apb_write(REG_RETRY_TIMEOUT, t);
    apb_write(REG_RETRY_LIMIT, l);
    apb_write(REG_FAIL_DELAY, d);
    apb_write(REG_START_ID, s);
    @(negedge clk);
  endtask

  task automatic push_item(item_kind_t kind, logic [IdW-1:0] rid, logic [CodeW-1:0] code,
                           bit track, logic [IdW-1:0] skew);
    claim_item_t it;
    it.kind = kind;
    it.rid = rid;
    it.code = code;
    it.track = track;
    it.skew = skew;
    it.gap = tx_quiet ? 0 : $urandom_range(0, 10);
    item_backlog.push_back(it);
  endtask

  // sender holds off until every request has its result
  task automatic settle();
    @(negedge clk);
    while (item_backlog.size() != 0 || s_tvalid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_burst(int unsigned n);
    int unsigned r;
    // restart the sequence so a long fail delay from earlier does not linger
    push_item(KIND_RESPONSE, '0, CodeW'($urandom_range(1, 15)), 1'b1, '0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        push_item(KIND_TICK, IdW'($urandom_range(0, 65535)), CodeW'($urandom_range(0, 15)),
                  1'b0, '0);
      else if (r < 80)
        push_item(KIND_RESPONSE, '0, CodeW'($urandom_range(0, 15)), 1'b1, '0);
      else if (r < 88)
        push_item(KIND_RESPONSE, '0, CodeW'($urandom_range(0, 15)), 1'b1,
                  $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
      else
        push_item(KIND_RESPONSE, IdW'($urandom_range(0, 65535)),
                  CodeW'($urandom_range(0, 15)), 1'b0, '0);
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults straight out of reset
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    push_item(KIND_RESPONSE, '0, '0, 1'b1, '0);
    push_item(KIND_RESPONSE, 16'hFFFF, 4'hF, 1'b0, '0);
    push_item(KIND_RESPONSE, '0, 4'hF, 1'b1, '0);
    push_item(KIND_TICK, 16'hFFFF, 4'hF, 1'b0, '0);
    push_item(KIND_RESPONSE, 16'h0000, 4'h0, 1'b0, '0);
    settle();

    // zero timeout and fail delay, id wraps past 0xffff
    set_knobs(0, 15, 0, 16'hFFFE);
    push_item(KIND_RESPONSE, '0, 4'h1, 1'b1, '0);
    repeat (3) push_item(KIND_TICK, '0, '0, 1'b0, '0);
    push_item(KIND_RESPONSE, '0, 4'h8, 1'b1, '0);
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    settle();

    set_knobs(255, 1, 65535, 16'h5A5A);
    push_item(KIND_RESPONSE, '0, 4'hF, 1'b1, '0);
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    settle();

    set_knobs(2, 2, 1, 16'h0100);
    push_item(KIND_RESPONSE, '0, 4'h2, 1'b1, '0);
    repeat (5) push_item(KIND_TICK, '0, '0, 1'b0, '0);
    settle();

    // claim attempts that keep drawing objections
    for (int p = 0; p < 4; p++) begin
      tx_quiet = (p == 0) || ($urandom_range(0, 2) == 0);
      rx_quiet = (p == 0) || ($urandom_range(0, 2) == 0);
      set_knobs($urandom_range(1, 6), $urandom_range(1, 15), $urandom_range(1, 8),
                $urandom_range(0, 65535));
      random_burst(95);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    set_knobs(255, 15, 65535, 16'hFFFF);
    random_burst(40);

    // zero retry limit lets the first expiry demand the name
    set_knobs(1, 0, 1, 16'h7FFF);
    allow_claim = 1'b1;
    push_item(KIND_RESPONSE, '0, 4'h4, 1'b1, '0);
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    push_item(KIND_RESPONSE, '0, 4'hF, 1'b1, '0);
    push_item(KIND_TICK, '0, '0, 1'b0, '0);
    push_item(KIND_RESPONSE, '0, 4'h0, 1'b1, '0);
    settle();

    // after the claim the machine only counts and reports objections
    set_knobs(0, 0, 0, $urandom_range(0, 65535));
    random_burst(50);
    rx_quiet = 1'b1;
    set_knobs($urandom_range(1, 255), $urandom_range(1, 15), $urandom_range(1, 65535),
              $urandom_range(0, 65535));
    random_burst(50);

    repeat (5) @(posedge clk);
    $display("%0d claim events driven, %0d broadcasts seen (%0d demands)",
             n_items, n_bcasts, n_demands);
    $display("%0d objections honored, name claimed: %0b", n_rejects, claimed);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("[name_registration_retry_machine] OK");
    end else begin
      $display("[name_registration_retry_machine] ERROR");
    end
    $finish;
  end

endmodule
